@@ hw/rtl/sll_pkg.sv @@
// Shared types and constants for the static linked list engine.
package sll_pkg;

    localparam int LINK_W    = 7;
    localparam int VALUE_W   = 32;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int DEPTH_DEF = 64;

    localparam logic [LINK_W-1:0] NULL_LINK = 7'd127;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_HEAD  = 2'd0,
        REQ_INS_AFTER = 2'd1,
        REQ_DELETE    = 2'd2,
        REQ_READ      = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_NOTHING = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_LINK,
        S_INS_FIX,
        S_HEAD_DEL,
        S_DEL_VICTIM,
        S_DEL_FIX,
        S_WALK
    } state_t;

    typedef struct packed {
        logic               rd_en;
        logic [LINK_W-1:0]  rd_addr;
        logic               val_we;
        logic               nxt_we;
        logic [LINK_W-1:0]  wr_addr;
        logic [VALUE_W-1:0] wr_value;
        logic [LINK_W-1:0]  wr_next;
    } mem_req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] rd_value;
        logic [LINK_W-1:0]  rd_next;
    } mem_rsp_t;

endpackage

@@ hw/rtl/static_linked_list_engine.sv @@
// Top level of the static linked list engine.
// A request is taken when start is high and busy is low. Inserting at the head,
// and any request that is refused on its node number or on the fill of the
// store, gives its item in the following cycle with busy staying low. Inserting
// after a node passes through the link and fix states, and deleting through the
// head-delete or the victim and fix states, as store reads are registered and
// the next-link memory has a single write port; a deletion after the tail is
// only found once the reference node has been read, so its status is set in the
// victim state. Reading out gives one item per cycle, one per node from head to
// tail, once the first memory read returns. Items appear for one cycle under
// strobe and cannot be held off, so the receiver must take them as they come.
// Node slots are never reused; after DEPTH insertions the store reports full.
module static_linked_list_engine #(
    parameter int DEPTH = sll_pkg::DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [sll_pkg::REQ_W-1:0]          req_type,
    input  logic [sll_pkg::LINK_W-1:0]         node_number,
    input  logic signed [sll_pkg::VALUE_W-1:0] value,
    output logic                               strobe,
    output logic signed [sll_pkg::VALUE_W-1:0] value_out,
    output logic [sll_pkg::STATUS_W-1:0]       status,
    output logic                               last
);
    import sll_pkg::*;

    mem_req_t mem_req;
    mem_rsp_t mem_rsp;

    sll_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .node_number (node_number),
        .value       (value),
        .strobe      (strobe),
        .value_out   (value_out),
        .status      (status),
        .last        (last),
        .mem_req     (mem_req),
        .mem_rsp     (mem_rsp)
    );

    sll_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .clk (clk),
        .req (mem_req),
        .rsp (mem_rsp)
    );

endmodule

@@ hw/rtl/sll_store.sv @@
// Value and next-link memories of the linked list, with registered read data.
module sll_store #(
    parameter int DEPTH = sll_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  sll_pkg::mem_req_t req,
    output sll_pkg::mem_rsp_t rsp
);
    import sll_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VALUE_W-1:0] value_mem [DEPTH];
    logic [LINK_W-1:0]  next_mem  [DEPTH];
    mem_rsp_t           rsp_reg;

    always_ff @(posedge clk)
    begin
        if (req.val_we)
        begin
            value_mem[req.wr_addr[AW-1:0]] <= req.wr_value;
        end
        if (req.nxt_we)
        begin
            next_mem[req.wr_addr[AW-1:0]] <= req.wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rsp_reg.rd_value <= value_mem[req.rd_addr[AW-1:0]];
            rsp_reg.rd_next  <= next_mem[req.rd_addr[AW-1:0]];
        end
    end

    assign rsp = rsp_reg;

endmodule

@@ hw/rtl/sll_ctrl.sv @@
// Request sequencer: head pointer, slot count, list updates and the read-out walk.
module sll_ctrl #(
    parameter int DEPTH = sll_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [sll_pkg::REQ_W-1:0]         req_type,
    input  logic [sll_pkg::LINK_W-1:0]        node_number,
    input  logic signed [sll_pkg::VALUE_W-1:0] value,
    output logic                              strobe,
    output logic signed [sll_pkg::VALUE_W-1:0] value_out,
    output logic [sll_pkg::STATUS_W-1:0]      status,
    output logic                              last,
    output sll_pkg::mem_req_t                 mem_req,
    input  sll_pkg::mem_rsp_t                 mem_rsp
);
    import sll_pkg::*;

    localparam logic [LINK_W-1:0] DEPTH_L = LINK_W'(DEPTH);
    localparam logic [LINK_W-1:0] WALK_MAX = LINK_W'(DEPTH - 1);

    state_t              state_reg, state_next;
    logic [LINK_W-1:0]   head_reg, head_next;
    logic [LINK_W-1:0]   used_reg, used_next;
    logic [LINK_W-1:0]   cnt_reg, cnt_next;
    logic [LINK_W-1:0]   ref_reg, ref_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic                strobe_reg, strobe_next;
    logic [VALUE_W-1:0]  vout_reg, vout_next;
    status_t             status_reg, status_next;
    logic                last_reg, last_next;

    logic accept;
    logic store_full;
    logic k_bad;
    logic k_zero;
    logic head_valid;
    logic rd_link_valid;
    logic walk_end;

    assign busy          = (state_reg != S_IDLE);
    assign accept        = start && !busy;
    assign store_full    = (used_reg >= DEPTH_L);
    assign k_zero        = (node_number == '0);
    assign k_bad         = k_zero || (node_number > used_reg);
    assign head_valid    = (head_reg < DEPTH_L);
    assign rd_link_valid = (mem_rsp.rd_next < DEPTH_L);
    assign walk_end      = !rd_link_valid || (cnt_reg == WALK_MAX);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_t'(req_type))
                        REQ_INS_HEAD:  state_next = S_IDLE;
                        REQ_INS_AFTER: state_next = (k_bad || store_full) ? S_IDLE : S_INS_LINK;
                        REQ_DELETE:
                        begin
                            if (k_zero)
                            begin
                                state_next = head_valid ? S_HEAD_DEL : S_IDLE;
                            end
                            else
                            begin
                                state_next = k_bad ? S_IDLE : S_DEL_VICTIM;
                            end
                        end
                        REQ_READ:      state_next = head_valid ? S_WALK : S_IDLE;
                        default:       state_next = S_IDLE;
                    endcase
                end
            end
            S_INS_LINK:   state_next = S_INS_FIX;
            S_INS_FIX:    state_next = S_IDLE;
            S_HEAD_DEL:   state_next = S_IDLE;
            S_DEL_VICTIM: state_next = rd_link_valid ? S_DEL_FIX : S_IDLE;
            S_DEL_FIX:    state_next = S_IDLE;
            S_WALK:       state_next = walk_end ? S_IDLE : S_WALK;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        mem_req     = '0;
        head_next   = head_reg;
        used_next   = used_reg;
        cnt_next    = cnt_reg;
        ref_next    = ref_reg;
        val_next    = val_reg;
        strobe_next = 1'b0;
        vout_next   = '0;
        status_next = ST_OK;
        last_next   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ref_next = node_number - LINK_W'(1);
                    val_next = value;
                    cnt_next = '0;
                    unique case (req_t'(req_type))
                        REQ_INS_HEAD:
                        begin
                            strobe_next = 1'b1;
                            if (store_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_req.val_we   = 1'b1;
                                mem_req.nxt_we   = 1'b1;
                                mem_req.wr_addr  = used_reg;
                                mem_req.wr_value = value;
                                mem_req.wr_next  = head_reg;
                                head_next        = used_reg;
                                used_next        = used_reg + LINK_W'(1);
                            end
                        end
                        REQ_INS_AFTER:
                        begin
                            if (k_bad)
                            begin
                                strobe_next = 1'b1;
                                status_next = ST_UNKNOWN;
                            end
                            else if (store_full)
                            begin
                                strobe_next = 1'b1;
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = node_number - LINK_W'(1);
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (k_zero)
                            begin
                                if (head_valid)
                                begin
                                    mem_req.rd_en   = 1'b1;
                                    mem_req.rd_addr = head_reg;
                                end
                                else
                                begin
                                    strobe_next = 1'b1;
                                    status_next = ST_NOTHING;
                                end
                            end
                            else if (k_bad)
                            begin
                                strobe_next = 1'b1;
                                status_next = ST_UNKNOWN;
                            end
                            else
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = node_number - LINK_W'(1);
                            end
                        end
                        REQ_READ:
                        begin
                            if (head_valid)
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = head_reg;
                            end
                            else
                            begin
                                strobe_next = 1'b1;
                                status_next = ST_EMPTY;
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b0;
                        end
                    endcase
                end
            end
            S_INS_LINK:
            begin
                mem_req.val_we   = 1'b1;
                mem_req.nxt_we   = 1'b1;
                mem_req.wr_addr  = used_reg;
                mem_req.wr_value = val_reg;
                mem_req.wr_next  = mem_rsp.rd_next;
            end
            S_INS_FIX:
            begin
                mem_req.nxt_we  = 1'b1;
                mem_req.wr_addr = ref_reg;
                mem_req.wr_next = used_reg;
                used_next       = used_reg + LINK_W'(1);
                strobe_next     = 1'b1;
            end
            S_HEAD_DEL:
            begin
                head_next   = mem_rsp.rd_next;
                strobe_next = 1'b1;
            end
            S_DEL_VICTIM:
            begin
                if (rd_link_valid)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = mem_rsp.rd_next;
                end
                else
                begin
                    strobe_next = 1'b1;
                    status_next = ST_NOTHING;
                end
            end
            S_DEL_FIX:
            begin
                mem_req.nxt_we  = 1'b1;
                mem_req.wr_addr = ref_reg;
                mem_req.wr_next = mem_rsp.rd_next;
                strobe_next     = 1'b1;
            end
            S_WALK:
            begin
                strobe_next = 1'b1;
                vout_next   = mem_rsp.rd_value;
                last_next   = walk_end;
                cnt_next    = cnt_reg + LINK_W'(1);
                if (!walk_end)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = mem_rsp.rd_next;
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= NULL_LINK;
            used_reg   <= '0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            used_reg   <= used_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ref_reg    <= ref_next;
        val_reg    <= val_next;
        vout_reg   <= vout_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign strobe    = strobe_reg;
    assign value_out = vout_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule
